// File: design/cvp_pkg.sv
// ----------------------------------------------------------------------------
// cvp_pkg
// Shared widths, the stage payload type and the arctangent table function
// for the CORDIC vectoring phase block.
// ----------------------------------------------------------------------------
`default_nettype none

package cvp_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int XY_W            = 17;
    localparam int PHASE_W         = 23;
    localparam int ITER_W          = 5;
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int SERIES_BITS     = 60;
    localparam int MAX_ITER_DEF    = 22;

    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(16);

    // pi/4 in units of 2^-60
    localparam logic [63:0] ATAN_ONE = 64'h0C90FDAA22168C23;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic        [PHASE_W-1:0] z;
    } t_cvp_data;

    // atan(2^-k) scaled by 2^ANGLE_FRAC_BITS, rounded to nearest; evaluated
    // at elaboration only.
    function automatic logic [PHASE_W-1:0] atan_entry(input int unsigned k);
        logic [63:0] v;
        logic [63:0] t;
        logic [63:0] r;
        int unsigned n;
        int unsigned sh;
        bit          neg;
        v   = '0;
        neg = 1'b0;
        sh  = SERIES_BITS - ANGLE_FRAC_BITS;
        if (k == 0) begin
            v = ATAN_ONE;
        end else begin
            for (n = 1; k * n <= SERIES_BITS; n += 2) begin
                t = (64'd1 << (SERIES_BITS - k * n)) / 64'(n);
                if (neg) begin
                    v = v - t;
                end else begin
                    v = v + t;
                end
                neg = !neg;
            end
        end
        r = (v + (64'd1 << (sh - 1)) - 64'd1) >> sh;
        return r[PHASE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/cordic_vectoring_phase_top.sv
// Phase of a complex sample by CORDIC in vectoring mode. One request carries
// a signed 16-bit I and Q; the block returns the 23-bit phase in radians
// scaled by 2^20, valid for positive I (no quadrant pre-rotation, no gain
// correction). The number of micro-rotations comes from the iterations
// register (reset 16, values above MAX_ITERATIONS act as MAX_ITERATIONS).
// A new sample is taken every clock unless every cell is full and the output
// stalls; each result passes through the chain of one registered cell per
// micro-rotation. Every cell holds its own request, so the chain keeps
// accepting samples into free cells while a result waits at the output.
// Write the iterations register only while no request is in flight.
// ----------------------------------------------------------------------------
// cordic_vectoring_phase_top
// Top level: stream ports, iterations register and the row of CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_vectoring_phase_top #(
    parameter int MAX_ITERATIONS = cvp_pkg::MAX_ITER_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [cvp_pkg::ITER_W-1:0]  i_cfg_wr_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] i_sample, [31:16] q_sample
    input  wire logic [31:0]                 s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [22:0] phase, [23] zero
    output logic [23:0]                      m_axis_tdata
);

    logic [cvp_pkg::ITER_W-1:0] r_iter;
    logic [MAX_ITERATIONS:0]    w_valid;
    logic [MAX_ITERATIONS:0]    w_ready;
    cvp_pkg::t_cvp_data         w_data [0:MAX_ITERATIONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= cvp_pkg::ITER_RESET;
        end else if (i_cfg_wr_en) begin
            r_iter <= i_cfg_wr_data;
        end
    end

    assign w_valid[0]  = s_axis_tvalid;
    assign s_axis_tready = w_ready[0];
    assign w_data[0].x = cvp_pkg::XY_W'($signed(s_axis_tdata[15:0]));
    assign w_data[0].y = cvp_pkg::XY_W'($signed(s_axis_tdata[31:16]));
    assign w_data[0].z = '0;

    for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_cell
        cvp_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_iterations (r_iter),
            .i_valid      (w_valid[k]),
            .o_ready      (w_ready[k]),
            .i_data       (w_data[k]),
            .o_valid      (w_valid[k+1]),
            .i_ready      (w_ready[k+1]),
            .o_data       (w_data[k+1])
        );
    end

    assign w_ready[MAX_ITERATIONS] = m_axis_tready;
    assign m_axis_tvalid = w_valid[MAX_ITERATIONS];
    assign m_axis_tdata  = {1'b0, w_data[MAX_ITERATIONS].z};

    // input back-pressure only when every cell holds a request
    a_full_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> &w_valid[MAX_ITERATIONS:1])
        else $error("input stalled with a free cell in the chain");

    // an accepted request lands in the first cell
    a_first_cell_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> w_valid[1])
        else $error("accepted request not held in first cell");

    // a waiting result keeps the last cell occupied
    a_last_cell_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[MAX_ITERATIONS] && !m_axis_tready |-> !w_ready[MAX_ITERATIONS-1])
        else $error("last cell reported free while its result waits");

endmodule

`default_nettype wire

// File: design/cvp_cell.sv
// ----------------------------------------------------------------------------
// cvp_cell
// One CORDIC vectoring micro-rotation with its own register stage and
// valid/ready handshake towards its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module cvp_cell #(
    parameter int IDX = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [cvp_pkg::ITER_W-1:0]   i_iterations,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire cvp_pkg::t_cvp_data           i_data,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output cvp_pkg::t_cvp_data                o_data
);

    localparam logic [cvp_pkg::PHASE_W-1:0] ATAN = cvp_pkg::atan_entry(IDX);

    logic                          r_valid;
    cvp_pkg::t_cvp_data            r_data;
    cvp_pkg::t_cvp_data            n_data;
    logic signed [cvp_pkg::XY_W-1:0] w_xs;
    logic signed [cvp_pkg::XY_W-1:0] w_ys;
    logic                          w_active;

    assign o_ready  = !r_valid || i_ready;
    assign w_xs     = i_data.x >>> IDX;
    assign w_ys     = i_data.y >>> IDX;
    assign w_active = i_iterations > cvp_pkg::ITER_W'(IDX);

    always_comb begin
        n_data = i_data;
        if (w_active) begin
            // rotate towards the positive I axis
            if (i_data.y[cvp_pkg::XY_W-1]) begin
                n_data.x = i_data.x - w_ys;
                n_data.y = i_data.y + w_xs;
                n_data.z = i_data.z - ATAN;
            end else begin
                n_data.x = i_data.x + w_ys;
                n_data.y = i_data.y - w_xs;
                n_data.z = i_data.z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: dv/tb_cordic_vectoring_phase_top.sv
// ----------------------------------------------------------------------------
// tb_cordic_vectoring_phase_top
// Streams I/Q samples through the CORDIC vectoring phase block under several
// iteration counts and idling patterns, and checks each phase result against
// a bit-exact software predictor held in a small scoreboard.
// ----------------------------------------------------------------------------

module tb_cordic_vectoring_phase_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROT     = cvp_pkg::MAX_ITER_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 170;

    localparam logic [15:0] POS_FULL = 16'h7FFF;
    localparam logic [15:0] NEG_FULL = 16'h8000;
    localparam logic [15:0] MINUS_1  = 16'hFFFF;

    // corner samples: both axes at their limits, origin, negative I
    localparam logic [15:0] CORNER_I [12] = '{
        POS_FULL, NEG_FULL, 16'h0000, 16'h0000, POS_FULL, NEG_FULL,
        POS_FULL, NEG_FULL, 16'h0000, MINUS_1, 16'h0001, NEG_FULL
    };
    localparam logic [15:0] CORNER_Q [12] = '{
        16'h0000, 16'h0000, POS_FULL, NEG_FULL, POS_FULL, NEG_FULL,
        NEG_FULL, POS_FULL, 16'h0000, MINUS_1, MINUS_1, MINUS_1
    };

    class phase_scoreboard;
        logic [cvp_pkg::PHASE_W-1:0] atan_lut [MAX_ROT];
        logic [cvp_pkg::ITER_W-1:0]  rotations;
        logic [cvp_pkg::PHASE_W-1:0] phase_q [$];
        int                          errors;

        function new();
            longint unsigned acc;
            longint unsigned term;
            bit              sub;
            for (int k = 0; k < MAX_ROT; k++) begin
                // atan(2^-k) in units of 2^-60, series for k > 0
                if (k == 0) begin
                    acc = 64'h0C90FDAA22168C23;
                end else begin
                    acc = 0;
                    sub = 1'b0;
                    for (int n = 1; k * n <= 60; n += 2) begin
                        term = (64'd1 << (60 - k * n)) / 64'(n);
                        acc  = sub ? acc - term : acc + term;
                        sub  = !sub;
                    end
                end
                acc = (acc + (64'd1 << 39) - 64'd1) >> 40;
                atan_lut[k] = acc[cvp_pkg::PHASE_W-1:0];
            end
            rotations = cvp_pkg::ITER_RESET;
            errors    = 0;
        endfunction

        function void set_rotations(logic [cvp_pkg::ITER_W-1:0] v);
            rotations = v;
        endfunction

        function logic [cvp_pkg::PHASE_W-1:0] vector_phase(logic signed [15:0] i_s,
                                                           logic signed [15:0] q_s);
            logic signed [16:0]          xr;
            logic signed [16:0]          yr;
            logic signed [16:0]          xn;
            logic signed [16:0]          yn;
            logic [cvp_pkg::PHASE_W-1:0] zr;
            int                          steps;
            xr    = i_s;
            yr    = q_s;
            zr    = '0;
            steps = (rotations > MAX_ROT) ? MAX_ROT : int'(rotations);
            for (int k = 0; k < steps; k++) begin
                if (yr[16]) begin
                    xn = xr - (yr >>> k);
                    yn = yr + (xr >>> k);
                    zr = zr - atan_lut[k];
                end else begin
                    xn = xr + (yr >>> k);
                    yn = yr - (xr >>> k);
                    zr = zr + atan_lut[k];
                end
                xr = xn;
                yr = yn;
            end
            return zr;
        endfunction

        function void note_request(logic [31:0] data);
            phase_q.push_back(vector_phase(data[15:0], data[31:16]));
        endfunction

        function void check_result(logic [23:0] data);
            logic [23:0] want;
            if (phase_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
            end else begin
                want = {1'b0, phase_q.pop_front()};
                if (data !== want) begin
                    $display("%0t: phase error, expected %h, got %h", $time, want, data);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return phase_q.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_wr_en   = 1'b0;
    logic [cvp_pkg::ITER_W-1:0] i_cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // [15:0] i_sample, [31:16] q_sample
    logic [31:0]                s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // [22:0] phase, [23] zero
    logic [23:0]                m_axis_tdata;

    phase_scoreboard sb;
    int              src_gap_pct = 0;
    int              dst_gap_pct = 0;
    int              cycle_count = 0;

    cordic_vectoring_phase_top #(
        .MAX_ITERATIONS(MAX_ROT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_request(s_axis_tdata);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                src_gap_pct = 12;
                dst_gap_pct = 74;
            end
            1: begin
                src_gap_pct = 74;
                dst_gap_pct = 12;
            end
            default: begin
                src_gap_pct = 0;
                dst_gap_pct = 0;
            end
        endcase
    endtask

    task automatic send_sample(input logic [15:0] i_s, input logic [15:0] q_s);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {q_s, i_s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drop valid, then hold until every outstanding request has returned
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (MAX_ROT + 2) @(posedge i_clk);
    endtask

    task automatic write_rotations(input logic [cvp_pkg::ITER_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_rotations(v);
    endtask

    function automatic logic [15:0] pick_field();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = POS_FULL;
            1: v = NEG_FULL;
            2: v = 16'($urandom_range(0, 255)) - 16'd128;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    initial begin
        logic [cvp_pkg::ITER_W-1:0] plan [RAND_PHASES];
        logic [cvp_pkg::ITER_W-1:0] edge_cfg [3];
        sb = new();
        plan = '{5'd22, 5'd1, 5'($urandom_range(2, 21)), 5'd31,
                 5'($urandom_range(2, 21)), 5'd16};
        edge_cfg = '{5'd0, 5'd22, 5'd31};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners under the reset count, then at zero, full and beyond full
        set_idling(0);
        foreach (CORNER_I[n]) send_sample(CORNER_I[n], CORNER_Q[n]);
        foreach (edge_cfg[c]) begin
            write_rotations(edge_cfg[c]);
            for (int n = 0; n < 4; n++) send_sample(CORNER_I[n + 4 * c], CORNER_Q[n + 4 * c]);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_idling(p / 2);
            write_rotations(plan[p]);
            repeat (PHASE_ITEMS) send_sample(pick_field(), pick_field());
        end

        drain();
        repeat (2 * MAX_ROT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: cordic_vectoring_phase_top.f
design/cvp_pkg.sv
design/cvp_cell.sv
design/cordic_vectoring_phase_top.sv
dv/tb_cordic_vectoring_phase_top.sv
